>>> sv/cpft_pkg.sv
// Shared types and constants for the camera projection / foreground test block.
// No dependencies.
package cpft_pkg;

  localparam int SUM_W           = 50;   // signed width of a projected component
  localparam int MAG_W           = 49;   // magnitude width of a component
  localparam int DIV_BITS        = 15;   // quotient bits below the saturation limit
  localparam int NEAR_ZERO_DEPTH = 6;    // |z| < 0.0001 in Q16.16
  localparam int NEAR_DIVISOR    = 65536;
  localparam logic [31:0] DIMS_RESET = 32'h0200_0200;
  localparam logic [15:0] THR_RESET  = 16'd80;

  typedef enum logic [2:0] {
    REG_ROW0_L = 3'd0,
    REG_ROW0_R = 3'd1,
    REG_ROW1_L = 3'd2,
    REG_ROW1_R = 3'd3,
    REG_ROW2_L = 3'd4,
    REG_ROW2_R = 3'd5,
    REG_DIMS   = 3'd6,
    REG_THR    = 3'd7
  } reg_idx_t;

  // 12 coefficients, row r coefficient k at index r*4+k
  typedef logic [11:0][31:0] coefs_t;

  // sideband that travels with every request
  typedef struct packed {
    logic        valid;
    logic        project;
    logic [8:0]  ld_col;
    logic [8:0]  ld_row;
    logic [15:0] ld_data;
  } tag_t;

endpackage

>>> sv/cpft_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module cpft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 262144
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/cpft_mac.sv
// Matrix stage: nine 32x32 products, then floored Q16.16 row sums.
// Depends on cpft_pkg.
module cpft_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  cpft_pkg::tag_t              tag_in,
  input  logic signed [31:0]          x,
  input  logic signed [31:0]          y,
  input  logic signed [31:0]          z,
  input  cpft_pkg::coefs_t            coefs,
  output cpft_pkg::tag_t              tag_out,
  output logic signed [cpft_pkg::SUM_W-1:0] px,
  output logic signed [cpft_pkg::SUM_W-1:0] py,
  output logic signed [cpft_pkg::SUM_W-1:0] pz
);
  cpft_pkg::tag_t     tag_p;
  logic signed [63:0] prod [0:2][0:2];
  logic signed [31:0] trans [0:2];
  logic signed [31:0] coord [0:2];
  logic signed [63:0] sum [0:2];

  assign coord[0] = x;
  assign coord[1] = y;
  assign coord[2] = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p <= '0;
    end else begin
      tag_p <= tag_in;
    end
    for (int r = 0; r < 3; r++) begin
      trans[r] <= $signed(coefs[r*4+3]);
      for (int k = 0; k < 3; k++) begin
        prod[r][k] <= 64'($signed(coefs[r*4+k])) * 64'(coord[k]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = (prod[r][0] >>> 16) + (prod[r][1] >>> 16) + (prod[r][2] >>> 16)
             + 64'(trans[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_p;
    end
    px <= sum[0][cpft_pkg::SUM_W-1:0];
    py <= sum[1][cpft_pkg::SUM_W-1:0];
    pz <= sum[2][cpft_pkg::SUM_W-1:0];
  end
endmodule

>>> sv/cpft_div.sv
// Pipelined floor divide of px, py by depth, one quotient bit per stage,
// with 16-bit saturation and the behind-camera case. Depends on cpft_pkg.
module cpft_div (
  input  logic                              clk,
  input  logic                              rst,
  input  cpft_pkg::tag_t                    tag_in,
  input  logic signed [cpft_pkg::SUM_W-1:0] px,
  input  logic signed [cpft_pkg::SUM_W-1:0] py,
  input  logic signed [cpft_pkg::SUM_W-1:0] pz,
  output cpft_pkg::tag_t                    tag_out,
  output logic [15:0]                       col,
  output logic [15:0]                       row
);
  localparam int NB = cpft_pkg::DIV_BITS;
  localparam int MW = cpft_pkg::MAG_W;

  cpft_pkg::tag_t  tag_st [0:NB];
  logic [MW-1:0]   d_st   [0:NB];
  logic            bh_st  [0:NB];
  logic [MW-1:0]   rem    [0:NB][0:1];
  logic [NB-1:0]   quo    [0:NB][0:1];
  logic            neg    [0:NB][0:1];
  logic            ov     [0:NB][0:1];

  logic [MW-1:0]   d0;
  logic [MW-1:0]   n0 [0:1];
  logic            s0 [0:1];

  // divisor 65536 at near-zero depth gives floor(p / 65536)
  always_comb begin
    if (pz <= cpft_pkg::SUM_W'(cpft_pkg::NEAR_ZERO_DEPTH)) begin
      d0 = MW'(cpft_pkg::NEAR_DIVISOR);
    end else begin
      d0 = pz[MW-1:0];
    end
    s0[0] = px[cpft_pkg::SUM_W-1];
    s0[1] = py[cpft_pkg::SUM_W-1];
    // floor of a negative: ~floor(~p / d)
    n0[0] = s0[0] ? ~px[MW-1:0] : px[MW-1:0];
    n0[1] = s0[1] ? ~py[MW-1:0] : py[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_st[0] <= '0;
    end else begin
      tag_st[0] <= tag_in;
    end
    d_st[0]  <= d0;
    bh_st[0] <= pz[cpft_pkg::SUM_W-1];
    for (int l = 0; l < 2; l++) begin
      rem[0][l] <= n0[l];
      quo[0][l] <= '0;
      neg[0][l] <= s0[l];
      ov[0][l]  <= {15'd0, n0[l]} >= {d0, 15'd0};
    end
  end

  for (genvar s = 0; s < NB; s++) begin : g_step
    logic [63:0] dsh;
    logic        ge [0:1];

    always_comb begin
      dsh = {15'd0, d_st[s]} << (NB - 1 - s);
      for (int l = 0; l < 2; l++) begin
        ge[l] = {15'd0, rem[s][l]} >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_st[s+1] <= '0;
      end else begin
        tag_st[s+1] <= tag_st[s];
      end
      d_st[s+1]  <= d_st[s];
      bh_st[s+1] <= bh_st[s];
      for (int l = 0; l < 2; l++) begin
        rem[s+1][l] <= ge[l] ? MW'({15'd0, rem[s][l]} - dsh) : rem[s][l];
        quo[s+1][l] <= {quo[s][l][NB-2:0], ge[l]};
        neg[s+1][l] <= neg[s][l];
        ov[s+1][l]  <= ov[s][l];
      end
    end
  end

  logic [15:0] val [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      val[l] = ov[NB][l] ? 16'h7fff : {1'b0, quo[NB][l]};
      if (neg[NB][l]) begin
        val[l] = ~val[l];
      end
      if (bh_st[NB]) begin
        val[l] = 16'hffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_st[NB];
    end
    col <= val[0];
    row <= val[1];
  end
endmodule

>>> sv/camera_project_foreground_test.sv
// Top level: camera projection with foreground test against a distance map.
// Depends on cpft_pkg, cpft_mac, cpft_div, cpft_ram.
//
//  channel   handshake           payload
//  request   start / busy        action, point_x/y/z, load_column/row, load_distance
//  result    done (one cycle)    pixel_col, pixel_row, inside_image, is_foreground
//  config    APB psel/penable    paddr, pwdata, prdata (64 bit, reg i at 8*i)
//
// One request per cycle; busy is never raised. A project request goes through
// the request register, the matrix stages, the divider's 15 quotient stages
// and the registered map read. Loads give no result and write the map in
// pipeline order. Reset clears the pipeline valid bits and configuration
// registers, not the map. The receiver cannot stall, so the pipeline never stops.
module camera_project_foreground_test #(
  parameter int MAP_WIDTH  = 512,
  parameter int MAP_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [8:0]         load_column,
  input  logic [8:0]         load_row,
  input  logic [15:0]        load_distance,
  output logic               done,
  output logic signed [15:0] pixel_col,
  output logic signed [15:0] pixel_row,
  output logic               inside_image,
  output logic               is_foreground,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  localparam int DEPTH   = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW      = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW      = MAP_WIDTH > 1 ? $clog2(MAP_WIDTH) : 1;
  localparam int RW      = MAP_HEIGHT > 1 ? $clog2(MAP_HEIGHT) : 1;
  localparam int LATENCY = 22;

  // ---------------- configuration registers ----------------
  logic [63:0] mat [0:5];
  logic [31:0] dims;
  logic [15:0] thr;
  cpft_pkg::reg_idx_t widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign widx   = cpft_pkg::reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        mat[i] <= '0;
      end
      dims <= cpft_pkg::DIMS_RESET;
      thr  <= cpft_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        cpft_pkg::REG_DIMS: dims <= pwdata[31:0];
        cpft_pkg::REG_THR:  thr  <= pwdata[15:0];
        default:            mat[paddr[5:3]] <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      cpft_pkg::REG_DIMS: prdata = {32'd0, dims};
      cpft_pkg::REG_THR:  prdata = {48'd0, thr};
      default:            prdata = mat[paddr[5:3]];
    endcase
  end

  cpft_pkg::coefs_t coefs;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coefs[r*4+0] = mat[2*r][31:0];
      coefs[r*4+1] = mat[2*r][63:32];
      coefs[r*4+2] = mat[2*r+1][31:0];
      coefs[r*4+3] = mat[2*r+1][63:32];
    end
  end

  // ---------------- request register ----------------
  cpft_pkg::tag_t     tag0;
  logic signed [31:0] x0, y0, z0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0 <= '0;
    end else begin
      tag0.valid   <= start && !busy;
      tag0.project <= action;
      tag0.ld_col  <= load_column;
      tag0.ld_row  <= load_row;
      tag0.ld_data <= load_distance;
    end
    x0 <= point_x;
    y0 <= point_y;
    z0 <= point_z;
  end

  // ---------------- matrix and divide ----------------
  cpft_pkg::tag_t                    tag_m, tag_d;
  logic signed [cpft_pkg::SUM_W-1:0] px, py, pz;
  logic [15:0]                       col_d, row_d;

  cpft_mac u_mac (
    .clk(clk), .rst(rst), .tag_in(tag0), .x(x0), .y(y0), .z(z0), .coefs(coefs),
    .tag_out(tag_m), .px(px), .py(py), .pz(pz)
  );

  cpft_div u_div (
    .clk(clk), .rst(rst), .tag_in(tag_m), .px(px), .py(py), .pz(pz),
    .tag_out(tag_d), .col(col_d), .row(row_d)
  );

  // ---------------- bounds, map access ----------------
  // loads write at the same stage the projections read, so order is kept
  logic [15:0]   wlim, hlim;
  logic          in_b, ld_ok;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   rdata;

  always_comb begin
    wlim  = (32'(dims[15:0]) > 32'(MAP_WIDTH))   ? 16'(MAP_WIDTH)  : dims[15:0];
    hlim  = (32'(dims[31:16]) > 32'(MAP_HEIGHT)) ? 16'(MAP_HEIGHT) : dims[31:16];
    // behind-camera pixels are -1 and fall out on the sign test
    in_b  = !col_d[15] && (col_d < wlim) && !row_d[15] && (row_d < hlim);
    ld_ok = tag_d.valid && !tag_d.project
         && (32'(tag_d.ld_col) < 32'(MAP_WIDTH)) && (32'(tag_d.ld_row) < 32'(MAP_HEIGHT));
    waddr = AW'(32'(tag_d.ld_row) * 32'(MAP_WIDTH) + 32'(tag_d.ld_col));
    raddr = AW'(32'(row_d[RW-1:0]) * 32'(MAP_WIDTH) + 32'(col_d[CW-1:0]));
  end

  cpft_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(ld_ok), .waddr(waddr), .wdata(tag_d.ld_data),
    .raddr(raddr), .rdata(rdata)
  );

  logic        a_valid, a_inside;
  logic [15:0] a_col, a_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= tag_d.valid && tag_d.project;
    end
    a_col    <= col_d;
    a_row    <= row_d;
    a_inside <= in_b;
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= a_valid;
    end
    pixel_col     <= a_col;
    pixel_row     <= a_row;
    inside_image  <= a_inside;
    is_foreground <= a_inside && (rdata <= thr);
  end

`ifndef NO_ASSERTIONS
  a_fg_inside: assert property (@(posedge clk) disable iff (rst)
    done && is_foreground |-> inside_image)
    else $error("foreground outside the image");

  a_inside_pos: assert property (@(posedge clk) disable iff (rst)
    done && inside_image |-> !pixel_col[15] && !pixel_row[15])
    else $error("inside pixel with negative coordinate");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && action, LATENCY))
    else $error("result without a project request");
`endif
endmodule
